@@ rtl/sse_pkg.sv @@
`default_nettype none

package sse_pkg;

  // element ids and limits
  localparam logic [7:0] SSID_ID      = 8'd0;
  localparam logic [7:0] MESH_ID      = 8'd114;
  localparam int unsigned MAX_SSID_LEN = 32;
  localparam logic [7:0] MAX_LEN_B    = 8'(MAX_SSID_LEN);

  // printable range and excluded character
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ssid_char;
    status_e    ssid_status;
    logic       mesh_seen;
    logic       run_end;
  } result_t;

  // results produced by one byte, character first
  typedef struct packed {
    logic    push_char;
    logic    push_sum;
    result_t char_res;
    result_t sum_res;
  } push_t;

  function automatic logic keep_char(input logic [7:0] c);
    return (c > CH_SPACE) && (c <= CH_TILDE) && (c != CH_BSLASH);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssid_element_extractor.sv @@
`default_nettype none

// Walks a buffer of information elements, one byte per transfer, and emits the
// printable characters of the first SSID element (id 0 or 114, length 1..32),
// backslash and space excepted, followed on the final byte by a summary result
// carrying the ssid status and the mesh flag. A byte is taken every cycle while
// the queue has room: the element walk is a single registered step, and results
// go into a four entry queue that accepts a new byte while at least two slots
// are free. One byte can produce two results (a character, then the summary);
// those leave the queue one per output transfer, so a sustained rate of one byte
// per cycle holds as long as the output side is ready and no more than one
// result per byte is produced on average. Results are registered into the queue.
module ssid_element_extractor (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] ie_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      ssid_char_o,
  output logic [1:0]      ssid_status_o,
  output logic            mesh_seen_o,
  output logic            run_end_o
);

  sse_pkg::push_t   push;
  sse_pkg::result_t head;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  // element parser
  sse_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .ie_byte_i    (ie_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push)
  );

  // result queue
  sse_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head)
  );

  assign kind_o        = head.kind;
  assign ssid_char_o   = head.ssid_char;
  assign ssid_status_o = head.ssid_status;
  assign mesh_seen_o   = head.mesh_seen;
  assign run_end_o     = head.run_end;

endmodule

`default_nettype wire

@@ rtl/sse_parser.sv @@
`default_nettype none

module sse_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     ie_byte_i,
  input  wire logic           final_byte_i,
  output sse_pkg::push_t      push_o
);

  sse_pkg::phase_e phase_q, phase_d;
  logic [7:0] elem_id_q, elem_id_d;
  logic [7:0] remain_q, remain_d;
  logic       found_q, found_d;
  logic       in_ssid_q, in_ssid_d;
  logic       mesh_q, mesh_d;
  logic       len_ok_q, len_ok_d;
  logic       trunc;
  logic       emit_char;
  logic [7:0] remain_dec;

  assign remain_dec = remain_q - 8'd1;

  // per byte element walk
  always_comb begin
    phase_d   = phase_q;
    elem_id_d = elem_id_q;
    remain_d  = remain_q;
    found_d   = found_q;
    in_ssid_d = in_ssid_q;
    mesh_d    = mesh_q;
    len_ok_d  = len_ok_q;
    trunc     = 1'b0;
    emit_char = 1'b0;
    unique case (phase_q)
      sse_pkg::PH_LEN: begin
        remain_d = ie_byte_i;
        len_ok_d = (ie_byte_i != 8'd0) && (ie_byte_i <= sse_pkg::MAX_LEN_B);
        if (ie_byte_i == 8'd0) begin
          phase_d   = sse_pkg::PH_ID;
          in_ssid_d = 1'b0;
        end else begin
          phase_d   = sse_pkg::PH_BODY;
          in_ssid_d = len_ok_d && !found_q &&
                      ((elem_id_q == sse_pkg::SSID_ID) || (elem_id_q == sse_pkg::MESH_ID));
          trunc     = final_byte_i && in_ssid_d;
        end
      end
      sse_pkg::PH_BODY: begin
        emit_char = in_ssid_q && sse_pkg::keep_char(ie_byte_i);
        remain_d  = remain_dec;
        if (remain_dec == 8'd0) begin
          phase_d   = sse_pkg::PH_ID;
          found_d   = found_q | in_ssid_q;
          mesh_d    = mesh_q | ((elem_id_q == sse_pkg::MESH_ID) && len_ok_q);
          in_ssid_d = 1'b0;
        end else begin
          trunc = final_byte_i && in_ssid_q;
        end
      end
      default: begin
        elem_id_d = ie_byte_i;
        phase_d   = sse_pkg::PH_LEN;
      end
    endcase
  end

  // result words for this byte
  always_comb begin
    push_o.push_char             = accept_i && emit_char;
    push_o.push_sum              = accept_i && final_byte_i;
    push_o.char_res.kind         = sse_pkg::KIND_CHAR;
    push_o.char_res.ssid_char    = ie_byte_i;
    push_o.char_res.ssid_status  = sse_pkg::ST_NONE;
    push_o.char_res.mesh_seen    = 1'b0;
    push_o.char_res.run_end      = 1'b0;
    push_o.sum_res.kind          = sse_pkg::KIND_SUMMARY;
    push_o.sum_res.ssid_char     = 8'd0;
    push_o.sum_res.ssid_status   = trunc ? sse_pkg::ST_TRUNC :
                                   (found_d ? sse_pkg::ST_FOUND : sse_pkg::ST_NONE);
    push_o.sum_res.mesh_seen     = mesh_d;
    push_o.sum_res.run_end       = 1'b1;
  end

  // parser state, back to reset after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sse_pkg::PH_ID;
      elem_id_q <= 8'd0;
      remain_q  <= 8'd0;
      found_q   <= 1'b0;
      in_ssid_q <= 1'b0;
      mesh_q    <= 1'b0;
      len_ok_q  <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        phase_q   <= sse_pkg::PH_ID;
        elem_id_q <= 8'd0;
        remain_q  <= 8'd0;
        found_q   <= 1'b0;
        in_ssid_q <= 1'b0;
        mesh_q    <= 1'b0;
        len_ok_q  <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        elem_id_q <= elem_id_d;
        remain_q  <= remain_d;
        found_q   <= found_d;
        in_ssid_q <= in_ssid_d;
        mesh_q    <= mesh_d;
        len_ok_q  <= len_ok_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // characters only come out of a selected element body
  a_char_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push_char |-> (phase_q == sse_pkg::PH_BODY) && in_ssid_q)
    else $error("character emitted outside ssid body");

  // a final byte returns the parser to a clean start
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && final_byte_i) |=> (phase_q == sse_pkg::PH_ID) && !found_q && !mesh_q)
    else $error("parser state not cleared after final byte");
`endif

endmodule

`default_nettype wire

@@ rtl/sse_result_fifo.sv @@
`default_nettype none

module sse_result_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sse_pkg::push_t     push_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output sse_pkg::result_t        data_o
);

  sse_pkg::result_t mem_q [sse_pkg::FIFO_DEPTH];
  logic [sse_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sse_pkg::CNT_W-1:0] count_q;
  logic [sse_pkg::PTR_W-1:0] wr_ptr_nx;
  logic [sse_pkg::CNT_W-1:0] n_push;
  logic                      pop;
  sse_pkg::result_t          first_res;

  // room for two results keeps one byte per cycle flowing
  assign room_o    = count_q <= sse_pkg::CNT_W'(sse_pkg::FIFO_DEPTH - 2);
  assign valid_o   = count_q != '0;
  assign data_o    = mem_q[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  assign n_push    = sse_pkg::CNT_W'(push_i.push_char) + sse_pkg::CNT_W'(push_i.push_sum);
  assign wr_ptr_nx = wr_ptr_q + sse_pkg::PTR_W'(1);
  assign first_res = push_i.push_char ? push_i.char_res : push_i.sum_res;

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.push_char || push_i.push_sum) begin
      mem_q[wr_ptr_q] <= first_res;
    end
    if (push_i.push_char && push_i.push_sum) begin
      mem_q[wr_ptr_nx] <= push_i.sum_res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + sse_pkg::PTR_W'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + sse_pkg::PTR_W'(1);
      end
      count_q <= count_q + n_push - sse_pkg::CNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  // results are only written when two slots are free
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != '0) |-> room_o)
    else $error("result written without room");

  // fill count never passes the depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sse_pkg::CNT_W'(sse_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

@@ tb/tb_ssid_element_extractor.sv @@
`timescale 1ns / 1ps

module tb_ssid_element_extractor;
  import sse_pkg::*;

  localparam int N_BYTES     = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  // expected results of the element walk, checked in transfer order
  class ssid_scoreboard;
    result_t    expected_q[$];
    int         errors;
    int         bytes_seen;
    int         chars_seen;
    int         buffers_seen;
    int         found_cnt;
    int         trunc_cnt;
    int         mesh_cnt;
    phase_e     phase;
    logic [7:0] elem_id;
    logic [7:0] body_left;
    logic       ssid_done;
    logic       in_ssid;
    logic       mesh_flag;
    logic       len_ok;

    function new();
      clear_walk();
    endfunction

    function void clear_walk();
      phase     = PH_ID;
      elem_id   = '0;
      body_left = '0;
      ssid_done = 1'b0;
      in_ssid   = 1'b0;
      mesh_flag = 1'b0;
      len_ok    = 1'b0;
    endfunction

    function bit printable(logic [7:0] c);
      return c > CH_SPACE && c <= CH_TILDE && c != CH_BSLASH;
    endfunction

    // advance the walk by one accepted byte and queue what it yields
    function void note_byte(logic [7:0] b, logic fin);
      result_t r;
      logic    trunc;
      trunc = 1'b0;
      bytes_seen++;
      case (phase)
        PH_LEN: begin
          body_left = b;
          len_ok    = (b >= 8'd1) && (b <= MAX_LEN_B);
          if (b == 8'd0) begin
            // empty element ends at its length byte
            phase   = PH_ID;
            in_ssid = 1'b0;
          end else begin
            phase   = PH_BODY;
            in_ssid = len_ok && (elem_id == SSID_ID || elem_id == MESH_ID) && !ssid_done;
            if (fin && in_ssid) trunc = 1'b1;
          end
        end
        PH_BODY: begin
          if (in_ssid && printable(b)) begin
            r           = '0;
            r.kind      = KIND_CHAR;
            r.ssid_char = b;
            expected_q.push_back(r);
          end
          body_left = body_left - 8'd1;
          if (body_left == 8'd0) begin
            phase = PH_ID;
            if (in_ssid) ssid_done = 1'b1;
            if (elem_id == MESH_ID && len_ok) mesh_flag = 1'b1;
            in_ssid = 1'b0;
          end else if (fin && in_ssid) begin
            trunc = 1'b1;
          end
        end
        default: begin
          elem_id = b;
          phase   = PH_LEN;
        end
      endcase
      // end of buffer summary, then back to a fresh walk
      if (fin) begin
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.ssid_status = trunc ? ST_TRUNC : (ssid_done ? ST_FOUND : ST_NONE);
        r.mesh_seen   = mesh_flag;
        r.run_end     = 1'b1;
        expected_q.push_back(r);
        clear_walk();
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d char %h status %0d",
                 $time, got.kind, got.ssid_char, got.ssid_status);
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == KIND_SUMMARY) begin
        buffers_seen++;
        if (want.ssid_status == ST_FOUND) found_cnt++;
        if (want.ssid_status == ST_TRUNC) trunc_cnt++;
        if (want.mesh_seen) mesh_cnt++;
      end else begin
        chars_seen++;
      end
      cmp_field("kind", 8'(want.kind), 8'(got.kind));
      cmp_field("ssid_char", want.ssid_char, got.ssid_char);
      cmp_field("ssid_status", 8'(want.ssid_status), 8'(got.ssid_status));
      cmp_field("mesh_seen", 8'(want.mesh_seen), 8'(got.mesh_seen));
      cmp_field("run_end", 8'(want.run_end), 8'(got.run_end));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] ie_byte_i    = '0;
  logic       final_byte_i = 1'b0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       kind_o;
  logic [7:0] ssid_char_o;
  logic [1:0] ssid_status_o;
  logic       mesh_seen_o;
  logic       run_end_o;

  ssid_scoreboard sb;
  result_t        out_res;
  logic [7:0]     byte_q[$];
  int             sent;
  int             burst_left;
  bit             no_gaps;
  bit             end_flush;
  int             hold_seq;
  int             hold_seen;
  int             hold_left;
  rx_mode_e       rx_mode;
  int             rx_left;
  int             rx_tick;
  int             cycles;

  ssid_element_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ie_byte_i    (ie_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .ssid_char_o  (ssid_char_o),
    .ssid_status_o(ssid_status_o),
    .mesh_seen_o  (mesh_seen_o),
    .run_end_o    (run_end_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ssid_element_extractor verification failed");
      $finish;
    end
  end

  // observe both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(ie_byte_i, final_byte_i);
      if (out_valid_o && out_ready_i) begin
        out_res.kind        = kind_e'(kind_o);
        out_res.ssid_char   = ssid_char_o;
        out_res.ssid_status = status_e'(ssid_status_o);
        out_res.mesh_seen   = mesh_seen_o;
        out_res.run_end     = run_end_o;
        sb.check_result(out_res);
      end
    end
  end

  // output side: rotating stall patterns, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (end_flush) begin
        out_ready_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 4) == 0);
          default:   out_ready_i <= (rx_tick % 3 == 0);
        endcase
      end
    end
  end

  // offer one byte, in bursts separated by random gaps
  task automatic send_item(logic [7:0] b, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i   <= 1'b1;
    ie_byte_i    <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  // the queued bytes form one buffer, the last one marked final
  task automatic send_run();
    foreach (byte_q[i]) send_item(byte_q[i], i == byte_q.size() - 1);
  endtask

  // stop offering until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // well-formed element list with random content, sometimes cut short or ended on a lone id
  task automatic send_buffer();
    int         n_elem;
    int         len;
    int         r;
    int         cut;
    logic [7:0] id;
    byte_q.delete();
    n_elem = $urandom_range(1, 5);
    for (int e = 0; e < n_elem; e++) begin
      r  = $urandom_range(0, 9);
      id = (r < 4) ? SSID_ID : (r < 7) ? MESH_ID : 8'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 8) len = 0;
      else if (r < 78) len = $urandom_range(1, 8);
      else if (r < 90) len = $urandom_range(9, MAX_SSID_LEN);
      else if (r < 99) len = $urandom_range(MAX_SSID_LEN + 1, 40);
      else len = $urandom_range(41, 255);
      byte_q.push_back(id);
      byte_q.push_back(8'(len));
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        case (r)
          0: begin
            case ($urandom_range(0, 6))
              0: byte_q.push_back(CH_SPACE);
              1: byte_q.push_back(8'h21);
              2: byte_q.push_back(CH_TILDE);
              3: byte_q.push_back(8'h7F);
              4: byte_q.push_back(CH_BSLASH);
              5: byte_q.push_back(8'h00);
              default: byte_q.push_back(8'hFF);
            endcase
          end
          1, 2, 3, 4, 5, 6: byte_q.push_back(8'($urandom_range(8'h21, CH_TILDE)));
          default: byte_q.push_back(8'($urandom));
        endcase
      end
    end
    // buffer end: after the last element, inside some element, or on a lone id
    r = $urandom_range(0, 9);
    if (r >= 6 && r <= 8) begin
      cut = $urandom_range(1, byte_q.size());
      while (byte_q.size() > cut) void'(byte_q.pop_back());
    end else if (r == 9) begin
      byte_q.push_back(8'($urandom));
    end
    send_run();
  endtask

  task automatic send_noise();
    int n;
    byte_q.delete();
    n = $urandom_range(1, 12);
    repeat (n) byte_q.push_back(8'($urandom));
    send_run();
  endtask

  initial begin
    int  mark;
    bit  hold_done;
    bit  drain_done;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // complete ssid with range edges, backslash and space dropped
    byte_q = '{SSID_ID, 8'h04, 8'h21, CH_TILDE, CH_BSLASH, CH_SPACE};
    send_run();
    // empty element, then the buffer ends on an id byte
    byte_q = '{MESH_ID, 8'h00, 8'hFF};
    send_run();
    // mesh candidate cut inside its body
    byte_q = '{MESH_ID, 8'h02, 8'h41};
    send_run();
    // buffer ends on the length byte of an ssid candidate
    byte_q = '{SSID_ID, 8'h05};
    send_run();
    // ssid found, mesh after it, later candidate ignored, oversize length at the end
    byte_q = '{SSID_ID, 8'h01, 8'h7F, MESH_ID, 8'h01, 8'h30, SSID_ID, 8'h01, 8'h41,
               8'hDD, 8'h21};
    send_run();
    // single byte buffer
    byte_q = '{SSID_ID};
    send_run();
    drain();

    // random buffers
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (sent < N_BYTES) begin
      if (!hold_done && sent >= 500) begin
        // long output stall while input keeps coming
        hold_done = 1'b1;
        no_gaps   = 1'b1;
        burst_left = 0;
        hold_seq++;
        mark = sent;
        while (sent < mark + 60) send_buffer();
        no_gaps = 1'b0;
      end
      if (!drain_done && sent >= 1000) begin
        drain_done = 1'b1;
        drain();
      end
      if ($urandom_range(0, 99) < 85) send_buffer();
      else send_noise();
    end

    end_flush = 1'b1;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run: %0d bytes, %0d buffers, %0d ssid characters", sb.bytes_seen,
             sb.buffers_seen, sb.chars_seen);
    $display("buffer outcomes: %0d found, %0d truncated, %0d with mesh element",
             sb.found_cnt, sb.trunc_cnt, sb.mesh_cnt);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ssid_element_extractor verification clean");
    else
      $display("ssid_element_extractor verification failed");
    $finish;
  end

endmodule
